[hdl/magcal_pkg.sv]
// ----------------------------------------------------------------------------
// magcal_pkg
// Types, codes and constant tables shared by the magnetometer sequencer.
// ----------------------------------------------------------------------------
package magcal_pkg;

  localparam int GAIN_ONE_DEF = 16384;
  localparam int NUM_REGS     = 7;
  localparam int CMD_LEN      = 5;

  // bus action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RECEN = 3'd3;
  localparam logic [2:0] ACT_ACK   = 3'd4;
  localparam logic [2:0] ACT_NACK  = 3'd5;
  localparam logic [2:0] ACT_STOP  = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z = 3'd2;
  localparam logic [2:0] REG_SIGN     = 3'd3;
  localparam logic [2:0] REG_SEL_X    = 3'd4;
  localparam logic [2:0] REG_SEL_Y    = 3'd5;
  localparam logic [2:0] REG_SEL_Z    = 3'd6;

  localparam logic [7:0] READ_ADDR = 8'h3D;

  typedef struct packed {
    logic       cmd;
    logic       bus_error;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         tx_byte;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               field_valid;
    logic               gains_updated;
    logic               bus_fault;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [2:0]         sign_mask;
    logic [1:0]         sel_x;
    logic [1:0]         sel_y;
    logic [1:0]         sel_z;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       load_selftest;
    logic       load_cont;
    logic       store_rx;
    logic [7:0] rx_byte;
    logic [2:0] addr;
    logic       start_field;
    logic       start_gain;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               done;
    logic [7:0]         rd_byte;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
  } dp_stat_t;

  // command bytes: self-test or continuous mode
  function automatic logic [7:0] cmd_byte(input logic cont, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h3C;
      3'd1:    b = 8'h00;
      3'd2:    b = cont ? 8'h10 : 8'h11;
      3'd3:    b = 8'h20;
      3'd4:    b = cont ? 8'h00 : 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/magnetometer_i2c_sequencer_calibrator.sv]
// ----------------------------------------------------------------------------
// magnetometer_i2c_sequencer_calibrator
// I2C message sequencer for a three-axis magnetometer with gain calibration.
// ----------------------------------------------------------------------------
//  port group    dir  handshake            word
//  in_*          in   in_valid/in_ready    in_word_t
//  out_*         out  out_valid/out_ready  out_word_t
//  cfg_*         in   cfg_write            index + 16-bit data
//
//  A bus step is written into the output register when it is accepted.
//  The closing step of a data read runs the shared multiplier over the three
//  axes, and the field result then goes into the output register.
//  The closing step of a self-test read runs the serial divider for each
//  axis whose reading is positive.
//  Input is held off while a datapath job runs or while a word waits unread.
//  Synchronous reset; gains return to GainOne, no clearing pass.
module magnetometer_i2c_sequencer_calibrator #(
  parameter int GainOne = magcal_pkg::GAIN_ONE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  magcal_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output magcal_pkg::out_word_t out_data,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import magcal_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x  <= '0;
      cfg.offset_y  <= '0;
      cfg.offset_z  <= '0;
      cfg.sign_mask <= '0;
      cfg.sel_x     <= 2'd0;
      cfg.sel_y     <= 2'd1;
      cfg.sel_z     <= 2'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OFFSET_X: cfg.offset_x  <= cfg_data;
        REG_OFFSET_Y: cfg.offset_y  <= cfg_data;
        REG_OFFSET_Z: cfg.offset_z  <= cfg_data;
        REG_SIGN:     cfg.sign_mask <= cfg_data[2:0];
        REG_SEL_X:    cfg.sel_x     <= cfg_data[1:0];
        REG_SEL_Y:    cfg.sel_y     <= cfg_data[1:0];
        REG_SEL_Z:    cfg.sel_z     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  magcal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .dcmd      (dcmd),
    .dstat     (dstat)
  );

  magcal_dp #(.GainOne(GainOne)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (dcmd),
    .stat (dstat)
  );

endmodule

[hdl/magcal_dp.sv]
// ----------------------------------------------------------------------------
// magcal_dp
// Byte buffer, axis gains, shared multiplier and serial gain divider.
// ----------------------------------------------------------------------------
module magcal_dp #(
  parameter int GainOne = magcal_pkg::GAIN_ONE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  magcal_pkg::cfg_t     cfg,
  input  magcal_pkg::dp_cmd_t  cmd,
  output magcal_pkg::dp_stat_t stat
);
  import magcal_pkg::*;

  localparam int                NUM     = 700 * GainOne;
  localparam int                NUMW    = $clog2(NUM + 1);
  localparam int                BCW     = $clog2(NUMW);
  localparam logic [NUMW-1:0]   NUM_V   = NUMW'(NUM);
  localparam logic [15:0]       GAIN_RV = 16'(GainOne);
  localparam logic [NUMW-1:0]   Q_MAX   = NUMW'(17'h0FFFF);
  localparam logic [BCW-1:0]    BC_TOP  = BCW'(NUMW - 1);

  localparam logic [2:0] DP_IDLE = 3'd0;
  localparam logic [2:0] DP_MUL  = 3'd1;
  localparam logic [2:0] DP_FLD  = 3'd2;
  localparam logic [2:0] DP_LOAD = 3'd3;
  localparam logic [2:0] DP_DIV  = 3'd4;
  localparam logic [2:0] DP_GST  = 3'd5;

  logic [7:0]         buffer [6];
  logic [15:0]        gain   [3];
  logic [2:0]         state;
  logic [1:0]         ax;
  logic [BCW-1:0]     bc;
  logic [NUMW-1:0]    num;
  logic [NUMW-1:0]    quot;
  logic [16:0]        rem;
  logic signed [31:0] prod;
  logic signed [15:0] fld [3];
  logic               done;
  logic               job_end;

  logic [1:0]         k_sel;
  logic [1:0]         k;
  logic [15:0]        raw;
  logic [2:0]         neg_bits;
  logic signed [15:0] off_sel;
  logic signed [15:0] scaled;
  logic signed [15:0] half;
  logic [16:0]        trial;
  logic               ge;
  logic signed [32:0] mul_full;

  // pick the sensor axis for this step
  always_comb begin
    case (ax)
      2'd0:    begin k_sel = cfg.sel_x; off_sel = cfg.offset_x; end
      2'd1:    begin k_sel = cfg.sel_y; off_sel = cfg.offset_y; end
      default: begin k_sel = cfg.sel_z; off_sel = cfg.offset_z; end
    endcase
    neg_bits = cfg.sign_mask;
    k = (state == DP_LOAD || state == DP_DIV || state == DP_GST) ? ax :
        ((k_sel > 2'd2) ? 2'd2 : k_sel);
    case (k)
      2'd0:    raw = {buffer[0], buffer[1]};
      2'd1:    raw = {buffer[2], buffer[3]};
      default: raw = {buffer[4], buffer[5]};
    endcase
  end

  assign mul_full = $signed(raw) * $signed({1'b0, gain[k]});
  assign scaled   = neg_bits[ax] ? -$signed(prod[29:14]) : $signed(prod[29:14]);
  assign half     = {off_sel[15], off_sel[15:1]};
  assign trial    = {rem[15:0], num[NUMW-1]};
  assign ge       = trial >= {1'b0, raw};

  // last step of a job: third axis finished
  assign job_end = (ax == 2'd2) &&
                   ((state == DP_FLD) || (state == DP_GST) ||
                    (state == DP_LOAD && (raw[15] || raw == 16'd0)));

  // buffer: command loads and received bytes
  always_ff @(posedge clk) begin
    if (cmd.load_selftest || cmd.load_cont) begin
      for (int i = 0; i < CMD_LEN; i++) begin
        buffer[i] <= cmd_byte(cmd.load_cont, 3'(i));
      end
    end else if (cmd.store_rx) begin
      buffer[cmd.addr] <= cmd.rx_byte;
    end
  end

  // sequencer for field scaling and gain division
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DP_IDLE;
      done  <= 1'b0;
      ax    <= 2'd0;
      for (int i = 0; i < 3; i++) gain[i] <= GAIN_RV;
    end else begin
      done <= job_end;
      case (state)
        DP_IDLE: begin
          ax <= 2'd0;
          if (cmd.start_field) state <= DP_MUL;
          else if (cmd.start_gain) state <= DP_LOAD;
        end
        DP_MUL: begin
          prod  <= mul_full[31:0];
          state <= DP_FLD;
        end
        DP_FLD: begin
          fld[ax] <= scaled - half;
          if (ax == 2'd2) begin
            state <= DP_IDLE;
          end else begin
            ax    <= ax + 2'd1;
            state <= DP_MUL;
          end
        end
        DP_LOAD: begin
          if (raw[15] || raw == 16'd0) begin
            gain[ax] <= GAIN_RV;
            if (ax == 2'd2) begin
              state <= DP_IDLE;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            rem   <= 17'd0;
            num   <= NUM_V;
            quot  <= '0;
            bc    <= BC_TOP;
            state <= DP_DIV;
          end
        end
        DP_DIV: begin
          rem  <= ge ? trial - {1'b0, raw} : trial;
          quot <= {quot[NUMW-2:0], ge};
          num  <= num << 1;
          bc   <= bc - 1'b1;
          if (bc == '0) state <= DP_GST;
        end
        DP_GST: begin
          gain[ax] <= (quot > Q_MAX) ? 16'hFFFF : quot[15:0];
          if (ax == 2'd2) begin
            state <= DP_IDLE;
          end else begin
            ax    <= ax + 2'd1;
            state <= DP_LOAD;
          end
        end
        default: state <= DP_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.done    = done;
    stat.rd_byte = (cmd.addr < 3'd6) ? buffer[cmd.addr] : 8'h00;
    stat.field_x = fld[0];
    stat.field_y = fld[1];
    stat.field_z = fld[2];
  end

endmodule

[hdl/magcal_ctrl.sv]
// ----------------------------------------------------------------------------
// magcal_ctrl
// Bus phase state machine, message counter and output register.
// ----------------------------------------------------------------------------
module magcal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  magcal_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output magcal_pkg::out_word_t out_data,
  output magcal_pkg::dp_cmd_t   dcmd,
  input  magcal_pkg::dp_stat_t  dstat
);
  import magcal_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_WR_START = 4'd1;
  localparam logic [3:0] PH_WR_DATA  = 4'd2;
  localparam logic [3:0] PH_WR_STOP  = 4'd3;
  localparam logic [3:0] PH_RD_START = 4'd4;
  localparam logic [3:0] PH_RD_ADDR  = 4'd5;
  localparam logic [3:0] PH_RD_RECEN = 4'd6;
  localparam logic [3:0] PH_RD_STORE = 4'd7;
  localparam logic [3:0] PH_RD_STOP  = 4'd8;
  localparam logic [3:0] PH_RD_DONE  = 4'd9;

  logic [3:0] phase, phase_next, ph;
  logic [2:0] message_count, mc_next;
  logic [2:0] byte_index, bi_next;
  logic       busy;
  logic       job_field;
  logic       accept;
  logic       has_res;
  out_word_t  res;
  out_word_t  job_res;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // work out one bus step for the incoming word
  always_comb begin
    ph         = phase;
    mc_next    = message_count;
    bi_next    = byte_index;
    res        = '0;
    dcmd       = '0;
    dcmd.addr  = byte_index;
    dcmd.rx_byte = in_data.rx_byte;
    if (!in_data.cmd) begin
      bi_next = 3'd0;
      if (message_count < 3'd4) mc_next = message_count + 3'd1;
      dcmd.load_selftest = accept && (mc_next == 3'd1);
      dcmd.load_cont     = accept && (mc_next == 3'd3);
      ph = mc_next[0] ? PH_WR_START : PH_RD_START;
    end
    phase_next = ph;
    if (in_data.bus_error) begin
      res.action    = ACT_STOP;
      res.bus_fault = 1'b1;
      phase_next    = PH_IDLE;
    end else begin
      case (ph)
        PH_IDLE: ;
        PH_WR_START: begin
          res.action = ACT_START;
          phase_next = PH_WR_DATA;
        end
        PH_WR_DATA: begin
          res.action  = ACT_SEND;
          res.tx_byte = dstat.rd_byte;
          bi_next     = byte_index + 3'd1;
          if (bi_next > 3'd4) phase_next = PH_WR_STOP;
        end
        PH_WR_STOP: begin
          res.action = ACT_STOP;
          phase_next = PH_IDLE;
        end
        PH_RD_START: begin
          res.action = ACT_START;
          phase_next = PH_RD_ADDR;
        end
        PH_RD_ADDR: begin
          res.action  = ACT_SEND;
          res.tx_byte = READ_ADDR;
          phase_next  = PH_RD_RECEN;
        end
        PH_RD_RECEN: begin
          res.action = ACT_RECEN;
          phase_next = PH_RD_STORE;
        end
        PH_RD_STORE: begin
          if (byte_index < 3'd6) begin
            dcmd.store_rx = accept;
            bi_next       = byte_index + 3'd1;
          end
          if (bi_next >= 3'd6) begin
            res.action = ACT_NACK;
            phase_next = PH_RD_STOP;
          end else begin
            res.action = ACT_ACK;
            phase_next = PH_RD_RECEN;
          end
        end
        PH_RD_STOP: begin
          res.action = ACT_STOP;
          phase_next = PH_RD_DONE;
        end
        PH_RD_DONE: begin
          dcmd.start_field = accept && (message_count == 3'd4);
          dcmd.start_gain  = accept && (message_count == 3'd2);
          phase_next       = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    has_res = (res.action != ACT_NONE) || res.bus_fault;
  end

  // build the word for a finished datapath job
  always_comb begin
    job_res               = '0;
    job_res.field_valid   = job_field;
    job_res.gains_updated = !job_field;
    if (job_field) begin
      job_res.field_x = dstat.field_x;
      job_res.field_y = dstat.field_y;
      job_res.field_z = dstat.field_z;
    end
  end

  // hold state, run jobs, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      message_count <= 3'd0;
      byte_index    <= 3'd0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        message_count <= mc_next;
        byte_index    <= bi_next;
        if (dcmd.start_field || dcmd.start_gain) begin
          busy      <= 1'b1;
          job_field <= dcmd.start_field;
        end
      end
      if (accept && has_res) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (busy && dstat.done) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        out_data  <= job_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/magcal_checker.sv]
// ----------------------------------------------------------------------------
// magcal_checker
// Port-level checks on the sequencer's result words.
// ----------------------------------------------------------------------------
module magcal_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input magcal_pkg::out_word_t out_data
);
  import magcal_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // tx byte only with a send
  a_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action != ACT_SEND |-> out_data.tx_byte == 8'h00)
    else $error("tx byte set without send");

  // a fault always carries a stop
  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bus_fault |-> out_data.action == ACT_STOP)
    else $error("fault without stop");

  // computed results carry no bus action and not both flags
  a_calc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.field_valid || out_data.gains_updated) |->
      out_data.action == ACT_NONE && !(out_data.field_valid && out_data.gains_updated))
    else $error("computed result mixed with bus action");

endmodule

bind magnetometer_i2c_sequencer_calibrator magcal_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/magnetometer_i2c_sequencer_calibrator_test.sv]
// ----------------------------------------------------------------------------
// magnetometer_i2c_sequencer_calibrator_test
// Self-checking bench for the magnetometer I2C sequencer. Bus steps are
// offered as input words and predicted one by one. The predictor covers the
// message counter, the transfer phases, the self-test gain calculation and
// the calibrated field. Each output word is checked field by field against
// the oldest prediction. Both sides idle at random, and the calibration
// registers change between phases of the run.
// ----------------------------------------------------------------------------
module magnetometer_i2c_sequencer_calibrator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import magcal_pkg::*;

  localparam int  GAIN_ONE    = GAIN_ONE_DEF;
  localparam int  NUM_ITEMS   = 750;
  localparam int  SETTLE      = 200;
  localparam longint LIMIT    = 1000000;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_WR_START, SQ_WR_DATA, SQ_WR_STOP, SQ_RD_START, SQ_RD_ADDR,
    SQ_RD_RECEN, SQ_RD_STORE, SQ_RD_STOP, SQ_RD_DONE
  } seq_phase_e;

  // Model of the sequencer and the store of words it still owes
  class bus_scoreboard;
    seq_phase_e phase;
    logic [2:0] msg_count;
    logic [2:0] byte_idx;
    logic [7:0] rx_buf [6];
    logic [15:0] gain [3];
    cfg_t cfg;
    out_word_t pending [$];
    int errors;

    function new();
      phase = SQ_IDLE;
      msg_count = 0;
      byte_idx = 0;
      foreach (rx_buf[i]) rx_buf[i] = 8'h00;
      foreach (gain[i]) gain[i] = 16'(GAIN_ONE);
      cfg = '0;
      cfg.sel_y = 2'd1;
      cfg.sel_z = 2'd2;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_OFFSET_X: cfg.offset_x = v;
        REG_OFFSET_Y: cfg.offset_y = v;
        REG_OFFSET_Z: cfg.offset_z = v;
        REG_SIGN:     cfg.sign_mask = v[2:0];
        REG_SEL_X:    cfg.sel_x = v[1:0];
        REG_SEL_Y:    cfg.sel_y = v[1:0];
        REG_SEL_Z:    cfg.sel_z = v[1:0];
        default: ;
      endcase
    endfunction

    function longint sensor_raw(int k);
      logic signed [15:0] v;
      v = {rx_buf[2*k], rx_buf[2*k+1]};
      return longint'(v);
    endfunction

    // Scale one sensor axis, flip if asked, remove half the offset
    function logic [15:0] calibrated(logic [1:0] sel, logic neg, logic signed [15:0] off);
      int k;
      longint s;
      longint half;
      k = (sel > 2) ? 2 : sel;
      s = (sensor_raw(k) * longint'(gain[k])) >>> 14;
      if (neg) s = -s;
      half = longint'(off) >>> 1;
      return 16'(s - half);
    endfunction

    function logic [7:0] cmd_byte_of(logic cont, logic [2:0] i);
      logic [7:0] t [5];
      t = '{8'h3C, 8'h00, cont ? 8'h10 : 8'h11, 8'h20, cont ? 8'h00 : 8'h01};
      return t[i];
    endfunction

    // Advance the model by one accepted word and queue what it yields
    function void note_word(in_word_t w);
      out_word_t r;
      longint raw;
      longint q;
      r = '0;
      if (!w.cmd) begin
        byte_idx = 0;
        if (msg_count < 4) msg_count++;
        if (msg_count == 1 || msg_count == 3) begin
          for (int i = 0; i < 5; i++) rx_buf[i] = cmd_byte_of(msg_count == 3, 3'(i));
        end
        phase = msg_count[0] ? SQ_WR_START : SQ_RD_START;
      end
      if (w.bus_error) begin
        r.action = ACT_STOP;
        r.bus_fault = 1'b1;
        phase = SQ_IDLE;
      end else begin
        case (phase)
          SQ_WR_START: begin
            r.action = ACT_START;
            phase = SQ_WR_DATA;
          end
          SQ_WR_DATA: begin
            r.action = ACT_SEND;
            r.tx_byte = (byte_idx < 6) ? rx_buf[byte_idx] : 8'h00;
            byte_idx = byte_idx + 1;
            if (byte_idx > 4) phase = SQ_WR_STOP;
          end
          SQ_WR_STOP: begin
            r.action = ACT_STOP;
            phase = SQ_IDLE;
          end
          SQ_RD_START: begin
            r.action = ACT_START;
            phase = SQ_RD_ADDR;
          end
          SQ_RD_ADDR: begin
            r.action = ACT_SEND;
            r.tx_byte = READ_ADDR;
            phase = SQ_RD_RECEN;
          end
          SQ_RD_RECEN: begin
            r.action = ACT_RECEN;
            phase = SQ_RD_STORE;
          end
          SQ_RD_STORE: begin
            if (byte_idx < 6) begin
              rx_buf[byte_idx] = w.rx_byte;
              byte_idx++;
            end
            if (byte_idx >= 6) begin
              r.action = ACT_NACK;
              phase = SQ_RD_STOP;
            end else begin
              r.action = ACT_ACK;
              phase = SQ_RD_RECEN;
            end
          end
          SQ_RD_STOP: begin
            r.action = ACT_STOP;
            phase = SQ_RD_DONE;
          end
          SQ_RD_DONE: begin
            if (msg_count == 4) begin
              r.field_x = calibrated(cfg.sel_x, cfg.sign_mask[0], cfg.offset_x);
              r.field_y = calibrated(cfg.sel_y, cfg.sign_mask[1], cfg.offset_y);
              r.field_z = calibrated(cfg.sel_z, cfg.sign_mask[2], cfg.offset_z);
              r.field_valid = 1'b1;
            end else if (msg_count == 2) begin
              for (int k = 0; k < 3; k++) begin
                raw = sensor_raw(k);
                if (raw > 0) begin
                  q = (longint'(700) * GAIN_ONE) / raw;
                  gain[k] = (q > 65535) ? 16'hFFFF : 16'(q);
                end else begin
                  gain[k] = 16'(GAIN_ONE);
                end
              end
              r.gains_updated = 1'b1;
            end
            phase = SQ_IDLE;
          end
          default: phase = SQ_IDLE;
        endcase
      end
      if (r.action != ACT_NONE || r.field_valid || r.gains_updated || r.bus_fault)
        pending.push_back(r);
    endfunction

    // Compare one output word with the oldest prediction
    function void check_word(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.action !== e.action) begin
        $display("%0t: action exp %0d got %0d", $time, e.action, got.action);
        errors++;
      end
      if (got.tx_byte !== e.tx_byte) begin
        $display("%0t: tx_byte exp %h got %h", $time, e.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.field_x !== e.field_x) begin
        $display("%0t: field_x exp %0d got %0d", $time, e.field_x, got.field_x);
        errors++;
      end
      if (got.field_y !== e.field_y) begin
        $display("%0t: field_y exp %0d got %0d", $time, e.field_y, got.field_y);
        errors++;
      end
      if (got.field_z !== e.field_z) begin
        $display("%0t: field_z exp %0d got %0d", $time, e.field_z, got.field_z);
        errors++;
      end
      if (got.field_valid !== e.field_valid) begin
        $display("%0t: field_valid exp %b got %b", $time, e.field_valid, got.field_valid);
        errors++;
      end
      if (got.gains_updated !== e.gains_updated) begin
        $display("%0t: gains_updated exp %b got %b", $time, e.gains_updated,
                 got.gains_updated);
        errors++;
      end
      if (got.bus_fault !== e.bus_fault) begin
        $display("%0t: bus_fault exp %b got %b", $time, e.bus_fault, got.bus_fault);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bus_scoreboard sb = new();
  longint cycles = 0;
  int     words_seen = 0;
  bit     quiet = 1'b0;

  magnetometer_i2c_sequencer_calibrator dut (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_write, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // Guard against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receive side: check every accepted word, stall at random
  initial begin
    int stall;
    int r;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_word(out_data);
        words_seen++;
      end
      if (!held && words_seen >= 200) begin
        held = 1'b1;
        stall = 500;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 60);
        end
      end
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // Drop valid for a random gap
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = quiet ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                           logic [2:0] sm, logic [1:0] sx, logic [1:0] sy, logic [1:0] sz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_SIGN, 16'(sm));
    write_reg(REG_SEL_X, 16'(sx));
    write_reg(REG_SEL_Y, 16'(sy));
    write_reg(REG_SEL_Z, 16'(sz));
  endtask

  function automatic in_word_t mk(logic c, logic e, logic [7:0] b);
    in_word_t w;
    w.cmd = c;
    w.bus_error = e;
    w.rx_byte = b;
    return w;
  endfunction

  // Stimulus
  initial begin
    logic [7:0] st_bytes [6];
    in_word_t w;
    int count;
    int r;
    st_bytes = '{8'h00, 8'h01, 8'h80, 8'h00, 8'h7F, 8'hFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle event, error on a request, self-test read, mode write
    send_word(mk(1'b1, 1'b0, 8'hFF));
    send_word(mk(1'b0, 1'b1, 8'h00));
    send_word(mk(1'b0, 1'b0, 8'hAA));
    send_word(mk(1'b1, 1'b0, 8'h00));
    send_word(mk(1'b1, 1'b0, 8'h00));
    for (int i = 0; i < 6; i++) begin
      send_word(mk(1'b1, 1'b0, st_bytes[i]));
      if (i < 5) send_word(mk(1'b1, 1'b0, 8'h55));
    end
    send_word(mk(1'b1, 1'b0, 8'h00));
    send_word(mk(1'b1, 1'b0, 8'h00));
    send_word(mk(1'b0, 1'b0, 8'h00));
    repeat (6) send_word(mk(1'b1, 1'b0, 8'h00));
    wait_drained();

    // Random: mostly whole data reads, some aborts and broken requests
    count = 0;
    while (count < NUM_ITEMS) begin
      if (count % 150 == 0) begin
        wait_drained();
        case (count / 150)
          0: write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd7, 2'd3, 2'd3, 2'd3);
          1: write_all(16'h8000, 16'h8000, 16'h8000, 3'd0, 2'd2, 2'd1, 2'd0);
          default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                             3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (sb.phase == SQ_IDLE) begin
        w = (r < 90) ? mk(1'b0, r < 3, 8'($urandom)) : mk(1'b1, r > 96, 8'($urandom));
      end else begin
        w = mk(r < 97, (r >= 94 && r < 97) || r == 99, 8'($urandom));
      end
      send_word(w);
      if (!(sb.phase == SQ_IDLE && w.cmd && !w.bus_error && sb.pending.size() == 0))
        count++;
      sender_gap();
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
